// ----- rtl/core/drt_pkg.sv -----
package drt_pkg;

    localparam int MAX_RECTS_DEF = 16;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_THRESH = 3'd2;
    localparam logic [2:0] REG_MERGE  = 3'd3;
    localparam logic [2:0] REG_DBUF   = 3'd4;

    localparam logic [1:0] ACT_RECT    = 2'd0;
    localparam logic [1:0] ACT_FULL    = 2'd1;
    localparam logic [1:0] ACT_PRESENT = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic               force_full;
    } t_in_word;

    typedef struct packed {
        logic [12:0] out_x;
        logic [12:0] out_y;
        logic [13:0] out_w;
        logic [13:0] out_h;
        logic        whole_frame;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [13:0] width;
        logic [13:0] height;
        logic [4:0]  thresh;
        logic        merge;
        logic        dbuf;
    } t_cfg;

endpackage

// ----- rtl/core/dirty_rect_tracker_top.sv -----
// invalidate: collapses to the whole frame at dispatch, else is clipped
// and then dropped, stored in an empty table, or scanned to append or re-merge entries
// present: a whole-frame word or one word per stored entry; no words when dbuf is off
// one item at a time; start is taken only while busy is low, results cannot be stalled
// synchronous active-low reset clears count and config to defaults; table is not cleared
module dirty_rect_tracker_top #(
    parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  drt_pkg::t_in_word  i_cmd,
    output logic               busy,
    output logic               o_valid,
    output drt_pkg::t_out_word o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import drt_pkg::*;

    t_cfg        r_cfg;
    logic [13:0] dim;
    logic [2:0]  idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign dim    = (pwdata[13:0] == 14'd0) ? 14'd1
                  : (pwdata[13:0] > 14'd8192) ? 14'd8192 : pwdata[13:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width: 14'd640, height: 14'd480, thresh: 5'd16, merge: 1'b1,
                       dbuf: 1'b1};
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_WIDTH:  r_cfg.width  <= dim;
                REG_HEIGHT: r_cfg.height <= dim;
                REG_THRESH: r_cfg.thresh <= pwdata[4:0];
                REG_MERGE:  r_cfg.merge  <= pwdata[0];
                REG_DBUF:   r_cfg.dbuf   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = {18'd0, r_cfg.width};
            REG_HEIGHT: prdata = {18'd0, r_cfg.height};
            REG_THRESH: prdata = {27'd0, r_cfg.thresh};
            REG_MERGE:  prdata = {31'd0, r_cfg.merge};
            REG_DBUF:   prdata = {31'd0, r_cfg.dbuf};
            default:    prdata = 32'd0;
        endcase
    end

    drt_engine #(.MAX_RECTS(MAX_RECTS)) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ----- rtl/core/drt_engine.sv -----
module drt_engine #(
    parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drt_pkg::t_cfg      i_cfg,
    input  logic               i_start,
    input  drt_pkg::t_in_word  i_cmd,
    output logic               o_busy,
    output logic               o_valid,
    output drt_pkg::t_out_word o_result
);
    import drt_pkg::*;

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int KW = ((CW > 5) ? CW : 5) + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECTS);

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [13:0] w;
        logic [13:0] h;
    } t_rect;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_CLIP2, ST_SCAN_RD, ST_SCAN_CHK, ST_PASS_RD,
        ST_PASS_CHK, ST_MOVE_RD, ST_MOVE_WR, ST_FINAL_WR, ST_PRES_RD, ST_PRES_OUT
    } t_state;

    function automatic logic touches(t_rect a, t_rect b);
        logic [14:0] ax1, bx1, ay1, by1;
        ax1 = {2'b0, a.x} + {1'b0, a.w};
        bx1 = {2'b0, b.x} + {1'b0, b.w};
        ay1 = {2'b0, a.y} + {1'b0, a.h};
        by1 = {2'b0, b.y} + {1'b0, b.h};
        return !(ax1 < {2'b0, b.x} || bx1 < {2'b0, a.x} ||
                 ay1 < {2'b0, b.y} || by1 < {2'b0, a.y});
    endfunction

    function automatic t_rect grow(t_rect d, t_rect s);
        logic [14:0] dx1, sx1, dy1, sy1, x1, y1;
        logic [12:0] x0, y0;
        t_rect r;
        dx1 = {2'b0, d.x} + {1'b0, d.w};
        sx1 = {2'b0, s.x} + {1'b0, s.w};
        dy1 = {2'b0, d.y} + {1'b0, d.h};
        sy1 = {2'b0, s.y} + {1'b0, s.h};
        x0 = (d.x < s.x) ? d.x : s.x;
        y0 = (d.y < s.y) ? d.y : s.y;
        x1 = (dx1 > sx1) ? dx1 : sx1;
        y1 = (dy1 > sy1) ? dy1 : sy1;
        r.x = x0;
        r.y = y0;
        r.w = 14'(x1 - {2'b0, x0});
        r.h = 14'(y1 - {2'b0, y0});
        return r;
    endfunction

    t_rect r_mem [MAX_RECTS];
    t_rect r_rd;

    t_state          r_state;
    t_in_word        r_cmd;
    logic [CW-1:0]   r_cnt, r_i, r_j;
    t_rect           r_g, r_c;
    logic [15:0]     r_lx, r_ly;
    logic signed [17:0] r_lw, r_lh;
    logic            r_valid;
    t_out_word       r_out;

    logic            we;
    logic [IW-1:0]   wa, ra;
    t_rect           wd;
    t_rect           full_rect, c_clip;
    logic            c_empty;
    logic signed [18:0] ex, ey, rw, rh;
    logic [CW-1:0]   last;
    logic            scan_end, app_full;

    always_comb begin
        full_rect = '{x: 13'd0, y: 13'd0, w: i_cfg.width, h: i_cfg.height};
        ex = 19'(signed'({1'b0, r_lx})) + 19'(r_lw);
        ey = 19'(signed'({1'b0, r_ly})) + 19'(r_lh);
        rw = (ex > signed'({5'b0, i_cfg.width}))
           ? signed'({5'b0, i_cfg.width}) - 19'(signed'({1'b0, r_lx})) : 19'(r_lw);
        rh = (ey > signed'({5'b0, i_cfg.height}))
           ? signed'({5'b0, i_cfg.height}) - 19'(signed'({1'b0, r_ly})) : 19'(r_lh);
        c_empty = (rw <= 19'sd0) || (rh <= 19'sd0);
        c_clip = '{x: r_lx[12:0], y: r_ly[12:0], w: rw[13:0], h: rh[13:0]};
        last = r_cnt - CW'(1);
        scan_end = (r_i >= r_cnt);
        app_full = (KW'(r_cnt) + KW'(1) > KW'(i_cfg.thresh)) || (r_cnt >= MAX_CNT);
    end

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = full_rect;
        unique case (r_state)
            ST_DISPATCH: begin
                if ((r_cmd.action == ACT_RECT && !i_cfg.merge) || r_cmd.action == ACT_FULL) begin
                    we = 1'b1;
                end
            end
            ST_CLIP2: begin
                if (!c_empty && r_cnt == '0) begin
                    we = 1'b1;
                    wd = c_clip;
                end
            end
            ST_SCAN_RD: begin
                if (scan_end) begin
                    we = 1'b1;
                    if (!app_full) begin
                        wa = r_cnt[IW-1:0];
                        wd = r_c;
                    end
                end
            end
            ST_MOVE_WR: begin
                we = 1'b1;
                wa = r_j[IW-1:0];
                wd = r_rd;
            end
            ST_FINAL_WR: begin
                we = 1'b1;
                wa = r_i[IW-1:0];
                wd = r_g;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_PASS_RD: ra = r_j[IW-1:0];
            ST_MOVE_RD: ra = last[IW-1:0];
            default:    ra = r_i[IW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    r_state <= ST_IDLE;
                    unique case (r_cmd.action)
                        ACT_RECT: begin
                            if (!i_cfg.merge) begin
                                r_cnt <= CW'(1);
                            end else begin
                                r_lx <= r_cmd.rect_x[15] ? 16'd0 : r_cmd.rect_x;
                                r_ly <= r_cmd.rect_y[15] ? 16'd0 : r_cmd.rect_y;
                                r_lw <= r_cmd.rect_x[15] ? 18'(r_cmd.rect_w) + 18'(r_cmd.rect_x)
                                                         : 18'(r_cmd.rect_w);
                                r_lh <= r_cmd.rect_y[15] ? 18'(r_cmd.rect_h) + 18'(r_cmd.rect_y)
                                                         : 18'(r_cmd.rect_h);
                                r_state <= ST_CLIP2;
                            end
                        end
                        ACT_FULL: r_cnt <= CW'(1);
                        ACT_PRESENT: begin
                            if (!i_cfg.dbuf) begin
                                r_cnt <= '0;
                            end else if (r_cmd.force_full || r_cnt == '0) begin
                                r_cnt   <= '0;
                                r_valid <= 1'b1;
                                r_out   <= '{out_x: 13'd0, out_y: 13'd0, out_w: i_cfg.width,
                                             out_h: i_cfg.height, whole_frame: 1'b1,
                                             last_of_run: 1'b1};
                            end else begin
                                r_i     <= '0;
                                r_state <= ST_PRES_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_CLIP2: begin
                    r_state <= ST_IDLE;
                    if (!c_empty) begin
                        if (r_cnt == '0) begin
                            r_cnt <= CW'(1);
                        end else begin
                            r_c     <= c_clip;
                            r_i     <= '0;
                            r_state <= ST_SCAN_RD;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (scan_end) begin
                        r_cnt   <= app_full ? CW'(1) : r_cnt + CW'(1);
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK: begin
                    if (touches(r_rd, r_c)) begin
                        r_g     <= grow(r_rd, r_c);
                        r_j     <= '0;
                        r_state <= ST_PASS_RD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_PASS_RD: begin
                    r_state <= (r_j >= r_cnt) ? ST_FINAL_WR : ST_PASS_CHK;
                end
                ST_PASS_CHK: begin
                    if (r_j != r_i && touches(r_g, r_rd)) begin
                        r_g <= grow(r_g, r_rd);
                        if (last == r_i) begin
                            r_i     <= r_j;
                            r_cnt   <= last;
                            r_state <= ST_PASS_RD;
                        end else begin
                            r_state <= ST_MOVE_RD;
                        end
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= ST_PASS_RD;
                    end
                end
                ST_MOVE_RD: r_state <= ST_MOVE_WR;
                ST_MOVE_WR: begin
                    r_cnt   <= last;
                    r_state <= ST_PASS_RD;
                end
                ST_FINAL_WR: r_state <= ST_IDLE;
                ST_PRES_RD: r_state <= ST_PRES_OUT;
                ST_PRES_OUT: begin
                    r_valid <= 1'b1;
                    r_out   <= '{out_x: r_rd.x, out_y: r_rd.y, out_w: r_rd.w, out_h: r_rd.h,
                                 whole_frame: 1'b0, last_of_run: (r_i + CW'(1) == r_cnt)};
                    if (r_i + CW'(1) == r_cnt) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= ST_PRES_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT) else $error("rect count above table size");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == ST_PRES_OUT || r_state == ST_DISPATCH))
        else $error("result strobe outside present");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.last_of_run) |-> r_cnt == '0) else $error("present left entries");
    a_grown_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS_CHK || r_state == ST_FINAL_WR) |-> r_i < r_cnt)
        else $error("grown entry beyond count");

endmodule

// ----- test/testbench.sv -----
module testbench;
    import drt_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } t_box;

    class rect_scoreboard;
        t_box       dirty[DEPTH];
        int         live_rects;
        int         scr_w;
        int         scr_h;
        int         thresh;
        bit         merge_on;
        bit         dbuf_on;
        t_out_word  pending[$];
        int         mismatches;
        int         words_checked;

        function void reset_state();
            live_rects = 0;
            scr_w = 640;
            scr_h = 480;
            thresh = 16;
            merge_on = 1;
            dbuf_on = 1;
        endfunction

        function int fit_dim(logic [31:0] v);
            int u;
            u = v[13:0];
            if (u == 0) return 1;
            if (u > 8192) return 8192;
            return u;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_WIDTH: scr_w = fit_dim(v);
                REG_HEIGHT: scr_h = fit_dim(v);
                REG_THRESH: thresh = v[4:0];
                REG_MERGE: merge_on = v[0];
                REG_DBUF: dbuf_on = v[0];
                default: ;
            endcase
        endfunction

        function bit adjacent(t_box a, t_box b);
            return !(a.x + a.w < b.x || b.x + b.w < a.x ||
                     a.y + a.h < b.y || b.y + b.h < a.y);
        endfunction

        function t_box union_of(t_box a, t_box b);
            t_box r;
            int x1;
            int y1;
            r.x = (a.x < b.x) ? a.x : b.x;
            r.y = (a.y < b.y) ? a.y : b.y;
            x1 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
            y1 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
            r.w = x1 - r.x;
            r.h = y1 - r.y;
            return r;
        endfunction

        function void to_full_screen();
            dirty[0].x = 0;
            dirty[0].y = 0;
            dirty[0].w = scr_w;
            dirty[0].h = scr_h;
            live_rects = 1;
        endfunction

        function void add_rect(t_box c);
            int i;
            int j;
            int last;
            if (c.x < 0) begin
                c.w += c.x;
                c.x = 0;
            end
            if (c.y < 0) begin
                c.h += c.y;
                c.y = 0;
            end
            if (c.x + c.w > scr_w) c.w = scr_w - c.x;
            if (c.y + c.h > scr_h) c.h = scr_h - c.y;
            if (c.w <= 0 || c.h <= 0) return;
            if (live_rects == 0) begin
                dirty[0] = c;
                live_rects = 1;
                return;
            end
            for (i = 0; i < live_rects; i++) begin
                if (adjacent(dirty[i], c)) begin
                    dirty[i] = union_of(dirty[i], c);
                    j = 0;
                    while (j < live_rects) begin
                        if (j != i && adjacent(dirty[i], dirty[j])) begin
                            last = live_rects - 1;
                            dirty[i] = union_of(dirty[i], dirty[j]);
                            dirty[j] = dirty[last];
                            if (last == i) i = j;
                            live_rects--;
                        end else begin
                            j++;
                        end
                    end
                    return;
                end
            end
            if (live_rects + 1 > thresh) begin
                to_full_screen();
                return;
            end
            if (live_rects < DEPTH) begin
                dirty[live_rects] = c;
                live_rects++;
            end else begin
                to_full_screen();
            end
        endfunction

        function t_out_word make_word(int x, int y, int w, int h, bit whole, bit last);
            t_out_word o;
            o.out_x = x[12:0];
            o.out_y = y[12:0];
            o.out_w = w[13:0];
            o.out_h = h[13:0];
            o.whole_frame = whole;
            o.last_of_run = last;
            return o;
        endfunction

        function void note_command(t_in_word cmd);
            t_box c;
            int k;
            case (cmd.action)
                ACT_RECT: begin
                    if (!merge_on) begin
                        to_full_screen();
                    end else begin
                        c.x = cmd.rect_x;
                        c.y = cmd.rect_y;
                        c.w = cmd.rect_w;
                        c.h = cmd.rect_h;
                        add_rect(c);
                    end
                end
                ACT_FULL: to_full_screen();
                ACT_PRESENT: begin
                    if (dbuf_on) begin
                        if (cmd.force_full || live_rects == 0) begin
                            pending.push_back(make_word(0, 0, scr_w, scr_h, 1, 1));
                        end else begin
                            for (k = 0; k < live_rects; k++)
                                pending.push_back(make_word(dirty[k].x, dirty[k].y,
                                    dirty[k].w, dirty[k].h, 0, k + 1 == live_rects));
                        end
                    end
                    live_rects = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            words_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_word    i_cmd;
    logic        busy;
    logic        o_valid;
    t_out_word   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rect_scoreboard tracker_sb;
    int  idle_cycles;
    int  commands_sent;
    int  presents_sent;

    dirty_rect_tracker_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd), .busy(busy),
        .o_valid(o_valid), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) tracker_sb.check_word(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return;
        if (r < 92) wait_cycles($urandom_range(1, 4));
        else wait_cycles($urandom_range(10, 60));
    endtask

    task automatic send_command(t_in_word cmd);
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker_sb.note_command(cmd);
        commands_sent++;
        if (cmd.action == ACT_PRESENT) presents_sent++;
        start <= 1'b0;
        @(posedge i_clk);
        random_gap();
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (tracker_sb.pending.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        wait_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker_sb.write_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_rect(int x, int y, int w, int h);
        t_in_word c;
        c = '0;
        c.action = ACT_RECT;
        c.rect_x = x[15:0];
        c.rect_y = y[15:0];
        c.rect_w = w[15:0];
        c.rect_h = h[15:0];
        send_command(c);
    endtask

    task automatic send_simple(logic [1:0] act, bit force_it);
        t_in_word c;
        c = t_in_word'($bits(t_in_word)'({$urandom, $urandom, $urandom}));
        c.action = act;
        c.force_full = force_it;
        send_command(c);
    endtask

    task automatic random_command(int span_w, int span_h);
        t_in_word c;
        int r;
        r = $urandom_range(0, 99);
        c = t_in_word'($bits(t_in_word)'({$urandom, $urandom, $urandom}));
        if (r < 70) begin
            c.action = ACT_RECT;
            c.rect_x = 16'($urandom_range(0, span_w + 20) - 10);
            c.rect_y = 16'($urandom_range(0, span_h + 20) - 10);
            c.rect_w = 16'($urandom_range(0, span_w / 4 + 2) - 1);
            c.rect_h = 16'($urandom_range(0, span_h / 4 + 2) - 1);
        end else if (r < 76) begin
            c.action = ACT_RECT;
        end else if (r < 80) begin
            c.action = ACT_FULL;
        end else if (r < 97) begin
            c.action = ACT_PRESENT;
            c.force_full = ($urandom_range(0, 5) == 0);
        end else begin
            c.action = 2'd3;
        end
        send_command(c);
    endtask

    task automatic random_phase(int n, int span_w, int span_h);
        repeat (n) random_command(span_w, span_h);
        send_simple(ACT_PRESENT, 1'b0);
        drain();
    endtask

    initial begin
        tracker_sb = new();
        tracker_sb.reset_state();
        tracker_sb.mismatches = 0;
        tracker_sb.words_checked = 0;
        idle_cycles = 0;
        commands_sent = 0;
        presents_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        wait_cycles(7);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty present, extremes, merges, collapse paths
        send_simple(ACT_PRESENT, 1'b0);
        send_rect(-32768, -32768, 32767, 32767);
        send_simple(ACT_PRESENT, 1'b0);
        send_rect(32767, 32767, 10, 10);
        send_rect(10, 10, 0, -32768);
        send_rect(10, 10, 20, 20);
        send_rect(100, 100, 20, 20);
        send_rect(200, 10, 20, 20);
        send_rect(30, 30, 5, 5);
        send_rect(50, 10, 200, 130);
        send_rect(630, 470, 100, 100);
        send_simple(ACT_PRESENT, 1'b0);
        send_rect(0, 0, 5, 5);
        send_rect(100, 0, 5, 5);
        send_rect(200, 0, 5, 5);
        send_rect(5, 0, 100, 5);
        send_simple(ACT_PRESENT, 1'b1);
        send_simple(ACT_FULL, 1'b0);
        send_simple(2'd3, 1'b1);
        send_simple(ACT_PRESENT, 1'b0);
        drain();

        write_cfg(REG_THRESH, 32'd3);
        for (int k = 0; k < 5; k++) send_rect(k * 40, 0, 10, 10);
        send_simple(ACT_PRESENT, 1'b0);
        drain();
        write_cfg(REG_THRESH, 32'd0);
        send_rect(3, 3, 3, 3);
        send_rect(20, 20, 3, 3);
        send_simple(ACT_PRESENT, 1'b0);
        drain();
        write_cfg(REG_MERGE, 32'd0);
        write_cfg(REG_THRESH, 32'd31);
        send_rect(0, 0, -5, -5);
        send_simple(ACT_PRESENT, 1'b0);
        drain();
        write_cfg(REG_MERGE, 32'd1);
        write_cfg(REG_DBUF, 32'd0);
        send_rect(1, 1, 2, 2);
        send_simple(ACT_PRESENT, 1'b0);
        drain();
        write_cfg(REG_DBUF, 32'd1);

        write_cfg(REG_WIDTH, 32'd640);
        write_cfg(REG_HEIGHT, 32'd480);
        write_cfg(REG_THRESH, 32'd16);
        random_phase(60, 640, 480);
        write_cfg(REG_WIDTH, 32'd8192);
        write_cfg(REG_HEIGHT, 32'd8192);
        random_phase(40, 8192, 8192);
        write_cfg(REG_WIDTH, 32'd0);
        write_cfg(REG_HEIGHT, 32'h3fff);
        write_cfg(REG_THRESH, 32'd8);
        random_phase(30, 8, 8192);
        write_cfg(REG_WIDTH, 32'd1);
        write_cfg(REG_HEIGHT, 32'd1);
        write_cfg(REG_THRESH, 32'd1);
        random_phase(20, 4, 4);
        write_cfg(REG_WIDTH, 32'd200);
        write_cfg(REG_HEIGHT, 32'd150);
        write_cfg(REG_THRESH, 32'd20);
        random_phase(50, 200, 150);
        write_cfg(REG_DBUF, 32'd0);
        write_cfg(REG_MERGE, 32'd0);
        random_phase(15, 200, 150);

        $display("sent %0d commands (%0d presents), checked %0d output words",
                 commands_sent, presents_sent, tracker_sb.words_checked);
        if (tracker_sb.mismatches == 0 && tracker_sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d words missing", tracker_sb.mismatches,
                     tracker_sb.pending.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/drt_pkg.sv
rtl/core/drt_engine.sv
rtl/core/dirty_rect_tracker_top.sv
test/testbench.sv
